// ===== rtl/mbd_pkg.sv =====
// Shared types and constants of the motion and bump detector.
`default_nettype none

package mbd_pkg;

	localparam int SENSOR_W = 4;
	localparam int POS_W    = 16;
	localparam int DELTA_W  = 17;
	localparam int REGION_W = 9;
	localparam int SQ_W     = 36;
	localparam int FRAME_W  = 32;
	localparam int REFR_W   = 16;

	// Result kinds as carried on the output tuser.
	localparam logic KIND_MOTION = 1'b0;
	localparam logic KIND_BUMP   = 1'b1;

	// Configuration register indexes (byte address is eight times the index).
	typedef enum logic [1:0] {
		REG_NOISE = 2'd0,
		REG_BUMP  = 2'd1,
		REG_REFR  = 2'd2
	} reg_idx_t;

	// One memory word: everything kept per sensor.
	typedef struct packed {
		logic signed [POS_W-1:0]   prev_x;
		logic signed [POS_W-1:0]   prev_y;
		logic signed [POS_W-1:0]   prev_z;
		logic                      armed;
		logic signed [DELTA_W-1:0] peak_x;
		logic signed [DELTA_W-1:0] peak_y;
		logic signed [DELTA_W-1:0] peak_z;
		logic [SQ_W-1:0]           peak_sq;
		logic [FRAME_W-1:0]        last_bump;
	} sens_state_t;

	// Up to two results caused by one sample, handed to the output stage.
	typedef struct packed {
		logic                       rec_v;
		logic                       bump_v;
		logic [SENSOR_W-1:0]        sensor;
		logic signed [REGION_W-1:0] region;
		logic signed [DELTA_W-1:0]  rec_x;
		logic signed [DELTA_W-1:0]  rec_y;
		logic signed [DELTA_W-1:0]  rec_z;
		logic signed [DELTA_W-1:0]  pk_x;
		logic signed [DELTA_W-1:0]  pk_y;
		logic signed [DELTA_W-1:0]  pk_z;
	} res_pair_t;

endpackage

`default_nettype wire

// ===== rtl/motion_bump_detector.sv =====
// Motion and bump detector: per-sensor state in one memory, read-modify-write pipeline.
// The first result of a sample passes the stage 1, stage 2 and output registers before it is shown.
// Throughput: one sample per cycle across sensors while the output does not stall; a sample of
// a sensor already in flight waits until the earlier one writes back (set by the memory RMW loop).
// A sample with two results holds the output register until both results have left.
// Reset restores the register defaults and clears the frame counter, the primed flags and
// the pipeline valids; the memory is not cleared.
`default_nettype none

module motion_bump_detector
	import mbd_pkg::*;
#(
	parameter int NUM_SENSORS = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic [63:0]      prdata,
	output logic             pready,
	// Sample input
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,  // sensor, pos_x, pos_y, pos_z, region,
	                                   // region_continuous, region_percussive, zero pad
	input  wire logic        s_tuser,  // frame_start
	// Result output
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,  // sensor_out, region_out, delta_x, delta_y, delta_z
	output logic             m_tuser,  // kind
	output logic             m_tlast
);

	localparam int SW = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;

	// Configuration registers
	logic [SQ_W-1:0]   noise_q;
	logic [SQ_W-1:0]   bthr_q;
	logic [REFR_W-1:0] refr_q;
	logic              cfg_wr;
	reg_idx_t          cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[4:3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_q <= 36'd96;
			bthr_q  <= 36'd60416;
			refr_q  <= 16'd8;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_NOISE: noise_q <= pwdata[SQ_W-1:0];
				REG_BUMP:  bthr_q  <= pwdata[SQ_W-1:0];
				REG_REFR:  refr_q  <= pwdata[REFR_W-1:0];
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (cfg_idx)
			REG_NOISE: prdata = {28'd0, noise_q};
			REG_BUMP:  prdata = {28'd0, bthr_q};
			REG_REFR:  prdata = {48'd0, refr_q};
			default:   prdata = 64'd0;
		endcase
	end

	// Input fields
	logic [SENSOR_W-1:0]        in_sensor;
	logic [REGION_W-1:0]        in_region;
	logic                       in_range;
	logic [SW-1:0]              in_addr;

	assign in_sensor = s_tdata[3:0];
	assign in_region = s_tdata[60:52];
	assign in_range  = ({28'd0, in_sensor} < 32'(NUM_SENSORS));
	assign in_addr   = in_sensor[SW-1:0];

	// Pipeline control
	logic v_s1;
	logic v_s2;
	logic adv1;
	logic adv2;
	logic ready1;
	logic ready2;
	logic hazard;
	logic acc;
	logic out_free;

	logic [SENSOR_W-1:0] sensor_s1;
	logic [SENSOR_W-1:0] sensor_s2;

	// A sample of a sensor still in flight must wait for its write-back.
	assign hazard   = (v_s1 && sensor_s1 == in_sensor) || (v_s2 && sensor_s2 == in_sensor);
	assign ready2   = !v_s2 || adv2;
	assign adv1     = v_s1 && ready2;
	assign ready1   = !v_s1 || adv1;
	assign s_tready = ready1 && !hazard;
	assign acc      = s_tvalid && s_tready;

	// Frame counter, advanced as the sample is accepted.
	logic [FRAME_W-1:0] fc_q;
	logic [FRAME_W-1:0] fc_inc;

	assign fc_inc = fc_q + FRAME_W'(s_tuser);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q <= '0;
		end else if (acc) begin
			fc_q <= fc_inc;
		end
	end

	// Per-sensor state memory and primed flags.
	sens_state_t            mem_q [NUM_SENSORS];
	logic [NUM_SENSORS-1:0] primed_q;
	sens_state_t            wst;

	// Stage 1 registers
	sens_state_t                rd_s1;
	logic                       pr_s1;
	logic [FRAME_W-1:0]         frame_s1;
	logic signed [POS_W-1:0]    px_s1;
	logic signed [POS_W-1:0]    py_s1;
	logic signed [POS_W-1:0]    pz_s1;
	logic signed [REGION_W-1:0] region_s1;
	logic                       cont_s1;
	logic                       perc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (acc) begin
			v_s1 <= in_range;
		end else if (adv1) begin
			v_s1 <= 1'b0;
		end
	end

	// Memory read is issued with the request; data lands in stage 1.
	always_ff @(posedge clk) begin
		if (acc) begin
			rd_s1     <= mem_q[in_addr];
			pr_s1     <= primed_q[in_addr];
			sensor_s1 <= in_sensor;
			frame_s1  <= fc_inc;
			px_s1     <= s_tdata[19:4];
			py_s1     <= s_tdata[35:20];
			pz_s1     <= s_tdata[51:36];
			region_s1 <= in_region[REGION_W-1] ? '1 : in_region;
			cont_s1   <= s_tdata[61];
			perc_s1   <= s_tdata[62];
		end
	end

	// Stage 1: motion and its squared components.
	sens_state_t               st1;
	logic signed [DELTA_W-1:0] dx1;
	logic signed [DELTA_W-1:0] dy1;
	logic signed [DELTA_W-1:0] dz1;
	logic signed [33:0]        sqx1;
	logic signed [33:0]        sqy1;
	logic signed [33:0]        sqz1;

	assign st1  = pr_s1 ? rd_s1 : '0;
	assign dx1  = {px_s1[POS_W-1], px_s1} - {st1.prev_x[POS_W-1], st1.prev_x};
	assign dy1  = {py_s1[POS_W-1], py_s1} - {st1.prev_y[POS_W-1], st1.prev_y};
	assign dz1  = {pz_s1[POS_W-1], pz_s1} - {st1.prev_z[POS_W-1], st1.prev_z};
	assign sqx1 = dx1 * dx1;
	assign sqy1 = dy1 * dy1;
	assign sqz1 = dz1 * dz1;

	// Stage 2 registers
	sens_state_t                st_s2;
	logic                       pr_s2;
	logic [FRAME_W-1:0]         frame_s2;
	logic signed [POS_W-1:0]    px_s2;
	logic signed [POS_W-1:0]    py_s2;
	logic signed [POS_W-1:0]    pz_s2;
	logic signed [REGION_W-1:0] region_s2;
	logic                       cont_s2;
	logic                       perc_s2;
	logic signed [DELTA_W-1:0]  dx_s2;
	logic signed [DELTA_W-1:0]  dy_s2;
	logic signed [DELTA_W-1:0]  dz_s2;
	logic [32:0]                sqx_s2;
	logic [32:0]                sqy_s2;
	logic [32:0]                sqz_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv1) begin
			v_s2 <= 1'b1;
		end else if (adv2) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			st_s2     <= st1;
			pr_s2     <= pr_s1;
			sensor_s2 <= sensor_s1;
			frame_s2  <= frame_s1;
			px_s2     <= px_s1;
			py_s2     <= py_s1;
			pz_s2     <= pz_s1;
			region_s2 <= region_s1;
			cont_s2   <= cont_s1;
			perc_s2   <= perc_s1;
			dx_s2     <= dx1;
			dy_s2     <= dy1;
			dz_s2     <= dz1;
			sqx_s2    <= sqx1[32:0];
			sqy_s2    <= sqy1[32:0];
			sqz_s2    <= sqz1[32:0];
		end
	end

	// Stage 2: squared distance and threshold decisions.
	logic [33:0]        dsq;
	logic [SQ_W-1:0]    dsq36;
	logic [SQ_W-1:0]    dsq4;
	logic [FRAME_W-1:0] elapsed;
	logic               reg_neg;
	logic               above_noise;
	logic               ref_ok;
	logic               arm_hit;
	logic               armed_n;
	logic               upd;
	logic               release_hit;
	logic               rec_v;
	logic               bump_v;
	logic               res_any;
	res_pair_t          pair;

	assign dsq         = 34'(sqx_s2) + 34'(sqy_s2) + 34'(sqz_s2);
	assign dsq36       = {2'b00, dsq};
	assign dsq4        = {dsq, 2'b00};
	assign elapsed     = frame_s2 - st_s2.last_bump;
	assign reg_neg     = region_s2[REGION_W-1];
	assign above_noise = dsq36 > noise_q;
	assign ref_ok      = elapsed >= {16'd0, refr_q};
	assign arm_hit     = dsq36 > bthr_q;
	assign armed_n     = st_s2.armed | arm_hit;
	assign upd         = arm_hit && (st_s2.peak_sq < dsq36);
	// After a peak update the new peak equals this distance, so no release.
	assign release_hit = armed_n && !upd && (dsq4 < st_s2.peak_sq);

	assign rec_v   = pr_s2 && above_noise && (reg_neg || cont_s2);
	assign bump_v  = pr_s2 && ref_ok && release_hit && !reg_neg && perc_s2;
	assign res_any = rec_v || bump_v;
	assign adv2    = v_s2 && (!res_any || out_free);

	// Results of this sample.
	always_comb begin
		pair        = '0;
		pair.rec_v  = rec_v;
		pair.bump_v = bump_v;
		pair.sensor = sensor_s2;
		pair.region = region_s2;
		pair.rec_x  = reg_neg ? '0 : dx_s2;
		pair.rec_y  = reg_neg ? '0 : dy_s2;
		pair.rec_z  = reg_neg ? '0 : dz_s2;
		pair.pk_x   = st_s2.peak_x;
		pair.pk_y   = st_s2.peak_y;
		pair.pk_z   = st_s2.peak_z;
	end

	// Updated state word for write-back.
	always_comb begin
		wst = st_s2;
		if (!pr_s2) begin
			wst = '0;
		end else if (ref_ok) begin
			if (!armed_n || release_hit) begin
				wst.armed   = 1'b0;
				wst.peak_x  = '0;
				wst.peak_y  = '0;
				wst.peak_z  = '0;
				wst.peak_sq = '0;
				if (armed_n) begin
					wst.last_bump = frame_s2;
				end
			end else begin
				wst.armed = 1'b1;
				if (upd) begin
					wst.peak_x  = dx_s2;
					wst.peak_y  = dy_s2;
					wst.peak_z  = dz_s2;
					wst.peak_sq = dsq36;
				end
			end
		end
		wst.prev_x = px_s2;
		wst.prev_y = py_s2;
		wst.prev_z = pz_s2;
	end

	// Write-back as the sample leaves stage 2.
	always_ff @(posedge clk) begin
		if (adv2) begin
			mem_q[sensor_s2[SW-1:0]] <= wst;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= '0;
		end else if (adv2) begin
			primed_q[sensor_s2[SW-1:0]] <= 1'b1;
		end
	end

	// Output register
	mbd_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (adv2 && res_any),
		.pair     (pair),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

`ifndef NO_ASSERTIONS
	// Two samples of one sensor are never in the RMW loop together.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2) |-> (sensor_s1 != sensor_s2))
		else $error("same sensor in stages 1 and 2");

	// A stalled stage 2 keeps its sample.
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !adv2) |=> (v_s2 && $stable(sensor_s2)))
		else $error("stage 2 lost its sample while stalled");

	// A bump needs the sensor armed before or by this sample.
	a_bump_armed: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && bump_v) |-> (st_s2.armed || arm_hit))
		else $error("bump without arming");

	// The frame counter moves by at most one per cycle.
	a_fc_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ((fc_q - $past(fc_q)) <= 32'd1))
		else $error("frame counter jumped");
`endif

endmodule

`default_nettype wire

// ===== rtl/mbd_out_stage.sv =====
// Output register that holds the results of one sample and serves them in order.
`default_nettype none

module mbd_out_stage
	import mbd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire res_pair_t   pair,
	output logic             free,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,  // sensor_out, region_out, delta_x, delta_y, delta_z
	output logic             m_tuser,  // kind
	output logic             m_tlast
);

	logic      rec_v_q;
	logic      bump_v_q;
	res_pair_t pair_q;
	logic      take;
	logic signed [DELTA_W-1:0] dx;
	logic signed [DELTA_W-1:0] dy;
	logic signed [DELTA_W-1:0] dz;

	// The motion record goes first; the bump follows when both are present.
	assign m_tvalid = rec_v_q | bump_v_q;
	assign m_tlast  = !(rec_v_q && bump_v_q);
	assign m_tuser  = rec_v_q ? KIND_MOTION : KIND_BUMP;
	assign dx       = rec_v_q ? pair_q.rec_x : pair_q.pk_x;
	assign dy       = rec_v_q ? pair_q.rec_y : pair_q.pk_y;
	assign dz       = rec_v_q ? pair_q.rec_z : pair_q.pk_z;
	assign m_tdata  = {dz, dy, dx, pair_q.region, pair_q.sensor};

	assign take = m_tvalid && m_tready;
	// Room for a new pair once the final result of the current one leaves.
	assign free = !m_tvalid || (m_tready && m_tlast);

	// Valid flags of the two result slots.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_v_q  <= 1'b0;
			bump_v_q <= 1'b0;
		end else if (push) begin
			rec_v_q  <= pair.rec_v;
			bump_v_q <= pair.bump_v;
		end else if (take) begin
			if (rec_v_q) begin
				rec_v_q <= 1'b0;
			end else begin
				bump_v_q <= 1'b0;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (push) begin
			pair_q <= pair;
		end
	end

endmodule

`default_nettype wire
